// ----- design/mpct_pkg.sv -----
// mpct_pkg: types and constants shared by the media position clock tracker
// no dependencies; the stage modules and the top level import it
`default_nettype none

package mpct_pkg;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned POS_W   = 40;
  localparam int unsigned SPEED_W = 11;
  localparam int unsigned EXTRA_W = 10;
  localparam int unsigned MS12_W  = 12;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned PROD_W  = MS12_W + SPEED_W;
  localparam int unsigned MEDIA_W = PROD_W - 8;

  localparam logic [SPEED_W-1:0] SPEED_MIN = SPEED_W'(64);
  localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(1024);

  localparam logic [SPEED_W-1:0] SPEED_RESET   = SPEED_W'(256);
  localparam logic [EXTRA_W-1:0] EXTRA_RESET   = EXTRA_W'(120);
  localparam logic [MS12_W-1:0]  STALE_RESET   = MS12_W'(500);
  localparam logic [MS12_W-1:0]  TOL_RESET     = MS12_W'(150);
  localparam logic [MS12_W-1:0]  TIMEOUT_RESET = MS12_W'(400);

  typedef enum logic [2:0] {
    MODE_RESET    = 3'd0,
    MODE_POSITION = 3'd1,
    MODE_DURATION = 3'd2,
    MODE_PAUSE    = 3'd3,
    MODE_END      = 3'd4,
    MODE_SEEK     = 3'd5,
    MODE_QUERY    = 3'd6
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SPEED   = 3'd0,
    CFG_EXTRA   = 3'd1,
    CFG_STALE   = 3'd2,
    CFG_TOL     = 3'd3,
    CFG_TIMEOUT = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_q8;
    logic [EXTRA_W-1:0] max_extrapolation_ms;
    logic [MS12_W-1:0]  stale_limit_ms;
    logic [MS12_W-1:0]  settle_tolerance_ms;
    logic [MS12_W-1:0]  settle_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [TIME_W-1:0] now_ms;
    logic [POS_W-1:0]  sample_ms;
    logic              flag_value;
    logic              value_present;
    logic              reset_emits_all;
  } evt_t;

  typedef struct packed {
    logic [POS_W-1:0] position_now_ms;
    logic [POS_W-1:0] duration_out_ms;
    logic             playing;
    logic             position_changed;
    logic             duration_changed;
    logic             playing_changed;
    logic             media_ended;
  } res_t;

  // flags reported with every item
  typedef struct packed {
    logic playing;
    logic position_changed;
    logic duration_changed;
    logic playing_changed;
    logic media_ended;
  } flags_t;

  // tracker state after one item, handed to the extrapolation stages
  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] last_update_ms;
    logic [POS_W-1:0]  last_position_ms;
    logic [POS_W-1:0]  duration_ms;
    logic              run_ok;
    flags_t            flags;
  } snap_t;

endpackage

`default_nettype wire

// ----- design/mpct_stream.sv -----
// mpct_stream: valid/ready channel carrying one payload item
// payload type is a parameter; the tracker uses types from mpct_pkg
`default_nettype none

interface mpct_stream #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/mpct_update.sv -----
// mpct_update: input register and tracker state update, one item per cycle while snap is not stalled
// depends on mpct_pkg and the mpct_stream interface
`default_nettype none

module mpct_update
  import mpct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  mpct_stream.sink   evt,
  mpct_stream.source snap
);

  typedef struct packed {
    logic [POS_W-1:0]  last_position_ms;
    logic [POS_W-1:0]  duration_ms;
    logic [TIME_W-1:0] last_update_ms;
    logic              update_valid;
    logic              seek_pending;
    logic [POS_W-1:0]  seek_target_ms;
    logic [TIME_W-1:0] guard_deadline_ms;
    logic              paused_flag;
    logic              ended_flag;
    logic              playing_flag;
  } trk_state_t;

  logic       s0_valid;
  evt_t       s0_item;
  logic       s1_valid;
  snap_t      s1_snap;
  trk_state_t state;
  trk_state_t state_next;
  snap_t      snap_next;
  logic       s1_ready;
  logic       advance;

  logic [POS_W:0]    dist_diff;
  logic [POS_W-1:0]  sample_gap;
  logic              settling;
  logic [TIME_W:0]   deadline_sum;
  logic [TIME_W-1:0] deadline;
  logic              play_new;
  logic              pos_chg;
  logic              dur_chg;
  logic              play_chg;
  logic              ended_evt;

  assign s1_ready  = !s1_valid || snap.ready;
  assign advance   = s0_valid && s1_ready;
  assign evt.ready = !s0_valid || s1_ready;
  assign snap.valid = s1_valid;
  assign snap.data  = s1_snap;

  // distance of a position sample from the seek target
  assign dist_diff = {1'b0, s0_item.sample_ms} - {1'b0, state.seek_target_ms};
  assign sample_gap = dist_diff[POS_W] ? (state.seek_target_ms - s0_item.sample_ms)
                                       : dist_diff[POS_W-1:0];
  assign settling = state.seek_pending && (s0_item.now_ms < state.guard_deadline_ms) &&
                    (sample_gap > POS_W'(cfg.settle_tolerance_ms));

  assign deadline_sum = {1'b0, s0_item.now_ms} + (TIME_W+1)'(cfg.settle_timeout_ms);
  assign deadline = deadline_sum[TIME_W] ? {TIME_W{1'b1}} : deadline_sum[TIME_W-1:0];

  always_comb begin
    state_next = state;
    pos_chg    = 1'b0;
    dur_chg    = 1'b0;
    play_chg   = 1'b0;
    ended_evt  = 1'b0;
    play_new   = 1'b0;
    case (mode_t'(s0_item.mode))
      MODE_RESET: begin
        state_next = '0;
        play_chg   = 1'b1;
        pos_chg    = s0_item.reset_emits_all;
        dur_chg    = s0_item.reset_emits_all;
      end
      MODE_POSITION: begin
        if (s0_item.value_present && !settling) begin
          state_next.seek_pending = 1'b0;
          if (s0_item.sample_ms != state.last_position_ms) begin
            state_next.last_position_ms = s0_item.sample_ms;
            state_next.last_update_ms   = s0_item.now_ms;
            state_next.update_valid     = 1'b1;
            pos_chg = 1'b1;
          end
        end
      end
      MODE_DURATION: begin
        if (s0_item.value_present && (s0_item.sample_ms != state.duration_ms)) begin
          state_next.duration_ms = s0_item.sample_ms;
          dur_chg = 1'b1;
        end
      end
      MODE_PAUSE: begin
        if (s0_item.value_present) begin
          state_next.paused_flag = s0_item.flag_value;
        end
      end
      MODE_END: begin
        if (s0_item.value_present) begin
          if (s0_item.flag_value && !state.ended_flag) begin
            state_next.ended_flag = 1'b1;
            ended_evt = 1'b1;
          end else if (!s0_item.flag_value) begin
            state_next.ended_flag = 1'b0;
          end
        end
      end
      MODE_SEEK: begin
        pos_chg = s0_item.sample_ms != state.last_position_ms;
        state_next.last_position_ms  = s0_item.sample_ms;
        state_next.seek_target_ms    = s0_item.sample_ms;
        state_next.seek_pending      = 1'b1;
        state_next.guard_deadline_ms = deadline;
        state_next.last_update_ms    = s0_item.now_ms;
        state_next.update_valid      = 1'b1;
      end
      default: begin
      end
    endcase
    // playing is re-evaluated on everything but a reset
    if (mode_t'(s0_item.mode) != MODE_RESET) begin
      play_new = !state_next.paused_flag && (state_next.duration_ms != '0) &&
                 !state_next.ended_flag;
      if (play_new != state.playing_flag) begin
        state_next.playing_flag = play_new;
        play_chg = 1'b1;
      end
    end
  end

  always_comb begin
    snap_next.now_ms           = s0_item.now_ms;
    snap_next.last_update_ms   = state_next.last_update_ms;
    snap_next.last_position_ms = state_next.last_position_ms;
    snap_next.duration_ms      = state_next.duration_ms;
    snap_next.run_ok           = state_next.playing_flag && state_next.update_valid;
    snap_next.flags.playing          = state_next.playing_flag;
    snap_next.flags.position_changed = pos_chg;
    snap_next.flags.duration_changed = dur_chg;
    snap_next.flags.playing_changed  = play_chg;
    snap_next.flags.media_ended      = ended_evt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      state    <= '0;
    end else begin
      if (evt.ready) begin
        s0_valid <= evt.valid;
      end
      if (s1_ready) begin
        s1_valid <= s0_valid;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s0_item <= evt.data;
    end
    if (advance) begin
      s1_snap <= snap_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/mpct_extrap.sv -----
// mpct_extrap: position extrapolation in two register stages, s2 and the result register
// depends on mpct_pkg and the mpct_stream interface
`default_nettype none

module mpct_extrap
  import mpct_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  mpct_stream.sink   snap,
  mpct_stream.source res
);

  typedef struct packed {
    logic               hold;
    logic [MEDIA_W-1:0] media_ms;
    logic [POS_W-1:0]   last_position_ms;
    logic [POS_W-1:0]   duration_ms;
    flags_t             flags;
  } s2_t;

  logic s2_valid;
  s2_t  s2;
  s2_t  s2_next;
  logic out_valid;
  res_t out_item;
  res_t out_next;
  logic out_ready;
  logic s2_ready;

  logic [TIME_W:0]      elapsed;
  logic [SPEED_W-1:0]   speed;
  logic [PROD_W-1:0]    product;
  logic [EXTRA_W-1:0]   media_c;
  logic [POS_W:0]       pos_sum;
  logic [POS_W-1:0]     pos_sat;

  assign out_ready  = !out_valid || res.ready;
  assign s2_ready   = !s2_valid || out_ready;
  assign snap.ready = s2_ready;
  assign res.valid  = out_valid;
  assign res.data   = out_item;

  assign speed = (cfg.speed_q8 < SPEED_MIN) ? SPEED_MIN :
                 (cfg.speed_q8 > SPEED_MAX) ? SPEED_MAX : cfg.speed_q8;

  // borrow out of the subtract means time ran backwards
  assign elapsed = {1'b0, snap.data.now_ms} - {1'b0, snap.data.last_update_ms};
  // elapsed fits in 12 bits whenever it is not stale
  assign product = PROD_W'(elapsed[MS12_W-1:0]) * PROD_W'(speed);

  always_comb begin
    s2_next.hold = !snap.data.run_ok || elapsed[TIME_W] ||
                   (elapsed[TIME_W-1:0] > TIME_W'(cfg.stale_limit_ms));
    s2_next.media_ms         = product[PROD_W-1:8];
    s2_next.last_position_ms = snap.data.last_position_ms;
    s2_next.duration_ms      = snap.data.duration_ms;
    s2_next.flags            = snap.data.flags;
  end

  assign media_c = (s2.media_ms > MEDIA_W'(cfg.max_extrapolation_ms)) ?
                   cfg.max_extrapolation_ms : s2.media_ms[EXTRA_W-1:0];
  assign pos_sum = {1'b0, s2.last_position_ms} + (POS_W+1)'(media_c);
  assign pos_sat = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];

  always_comb begin
    out_next.position_now_ms  = s2.hold ? s2.last_position_ms : pos_sat;
    out_next.duration_out_ms  = s2.duration_ms;
    out_next.playing          = s2.flags.playing;
    out_next.position_changed = s2.flags.position_changed;
    out_next.duration_changed = s2.flags.duration_changed;
    out_next.playing_changed  = s2.flags.playing_changed;
    out_next.media_ended      = s2.flags.media_ended;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid <= snap.valid;
      end
      if (out_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap.valid && s2_ready) begin
      s2 <= s2_next;
    end
    if (s2_valid && out_ready) begin
      out_item <= out_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/media_position_clock_tracker.sv -----
// media_position_clock_tracker: top level with configuration registers
// depends on mpct_pkg, mpct_stream, mpct_update and mpct_extrap
//
//   channel   dir   handshake      payload
//   evt       in    valid/ready    evt_t: mode, now_ms, sample_ms, flags
//   res       out   valid/ready    res_t: position, duration, status flags
//   cfg       in    cfg_we only    cfg_index, cfg_data (12 bits)
//
// one item per cycle sustained while res is not stalled; an accepted item passes s0, s1, s2 and the result register
// the state update register loop is the step that sets the rate
// rst is synchronous and clears state, stage valids and configuration to defaults
// a stalled result backs up the stages; evt.ready drops only when all are full
`default_nettype none

module media_position_clock_tracker
  import mpct_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  mpct_stream.sink                    evt,
  mpct_stream.source                  res
);

  cfg_t cfg;

  mpct_stream #(.payload_t(snap_t)) snap ();

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_q8             <= SPEED_RESET;
      cfg.max_extrapolation_ms <= EXTRA_RESET;
      cfg.stale_limit_ms       <= STALE_RESET;
      cfg.settle_tolerance_ms  <= TOL_RESET;
      cfg.settle_timeout_ms    <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_SPEED:   cfg.speed_q8             <= cfg_data[SPEED_W-1:0];
        CFG_EXTRA:   cfg.max_extrapolation_ms <= cfg_data[EXTRA_W-1:0];
        CFG_STALE:   cfg.stale_limit_ms       <= cfg_data[MS12_W-1:0];
        CFG_TOL:     cfg.settle_tolerance_ms  <= cfg_data[MS12_W-1:0];
        CFG_TIMEOUT: cfg.settle_timeout_ms    <= cfg_data[MS12_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mpct_update u_update (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .evt  (evt),
    .snap (snap.source)
  );

  mpct_extrap u_extrap (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .snap (snap.sink),
    .res  (res)
  );

endmodule

`default_nettype wire
